>>> hw/rtl/assert_macros.svh
// Assertion helper macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, quiet during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/pndw_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pndw_pkg
// Shared types and constants for the particle neighbor distance weight block.
// ---------------------------------------------------------------------------
package pndw_pkg;

  localparam int COORD_W  = 24;
  localparam int RADIUS_W = 24;
  localparam int IDX_W    = 6;
  localparam int CNT_W    = 7;
  localparam int QC_W     = 16;
  localparam int QO_W     = 18;
  localparam int W_W      = 17;
  localparam int DIFF_W   = 25;
  localparam int SQ_W     = 52;
  localparam int ROOT_W   = 26;
  localparam int RATIO_ONE = 65536;
  localparam logic [QO_W-1:0] OLD_RATIO_MAX = 18'h3FFFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FULL,
    ST_READ,
    ST_WAIT,
    ST_DIST,
    ST_CHECK,
    ST_DIST_OLD,
    ST_ROOT,
    ST_DIV,
    ST_KERN,
    ST_EMIT,
    ST_NEXT,
    ST_STORE
  } state_t;

  typedef enum logic [1:0] {
    OP_DIST,
    OP_ROOT,
    OP_DIV,
    OP_KERN
  } arith_op_t;

endpackage

>>> hw/rtl/pndw_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pndw_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module pndw_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/pndw_arith.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pndw_arith
// Shared iterative unit: squared distance, integer square root, ratio divide
// and the Wendland kernel, one small step per cycle under a start strobe.
// ---------------------------------------------------------------------------
module pndw_arith import pndw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  arith_op_t             op,
  input  logic                  start,
  input  logic [3*COORD_W-1:0]  pos_a,
  input  logic [3*COORD_W-1:0]  pos_b,
  input  logic [RADIUS_W-1:0]   radius,
  input  logic [SQ_W-1:0]       sq_in,
  input  logic [ROOT_W-1:0]     root_in,
  input  logic [QO_W-1:0]       q_in,
  output logic                  busy,
  output logic [SQ_W-1:0]       sq_out,
  output logic [ROOT_W-1:0]     root_out,
  output logic [ROOT_W+16-1:0]  quo_out,
  output logic [W_W-1:0]        w_out
);

  localparam int QUO_W = ROOT_W + 16; // full quotient, radius may be as small as one

  logic [5:0]          step;
  arith_op_t           cur_op;
  logic [SQ_W-1:0]     acc;
  logic [SQ_W-1:0]     rem;
  logic [ROOT_W-1:0]   res;
  logic [ROOT_W+16-1:0] dividend;
  logic [QUO_W-1:0]    quo;
  logic [RADIUS_W:0]   drem;
  logic [DIFF_W-1:0]   dabs;
  logic [2*DIFF_W-1:0] prod;
  logic [33:0]         kprod;
  logic [16:0]         m, m4;
  logic [18:0]         fac;

  // component difference for the distance op
  always_comb begin
    logic signed [DIFF_W-1:0] a, b, d;
    a = DIFF_W'($signed(pos_a[step[1:0]*COORD_W +: COORD_W]));
    b = DIFF_W'($signed(pos_b[step[1:0]*COORD_W +: COORD_W]));
    d = a - b;
    dabs = d[DIFF_W-1] ? DIFF_W'(-d) : d;
    prod = dabs * dabs;
  end

  // root trial
  logic [SQ_W+1:0] trial;
  logic [SQ_W+1:0] rem_sh;
  always_comb begin
    rem_sh = {rem, acc[SQ_W-1 -: 2]} ;
    trial  = {{(SQ_W-ROOT_W){1'b0}}, res, 2'b01};
  end

  // divide trial
  logic [RADIUS_W+1:0] dtrial;
  always_comb begin
    dtrial = {drem, dividend[ROOT_W+16-1]} - {2'b0, radius};
  end

  always_comb begin
    kprod = m * m;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy   <= 1'b1;
      step   <= '0;
      cur_op <= op;
      acc    <= (op == OP_ROOT) ? sq_in : '0;
      rem    <= '0;
      res    <= '0;
      quo    <= '0;
      drem   <= '0;
      m      <= 17'(RATIO_ONE) - 17'(q_in);
      dividend <= {root_in, 16'b0};
    end else if (busy) begin
      step <= step + 6'd1;
      unique case (cur_op)
        OP_DIST: begin
          acc <= acc + SQ_W'(prod);
          if (step == 6'd2) busy <= 1'b0;
        end
        OP_ROOT: begin
          acc <= {acc[SQ_W-3:0], 2'b00};
          if (rem_sh >= trial) begin
            rem <= SQ_W'(rem_sh - trial);
            res <= {res[ROOT_W-2:0], 1'b1};
          end else begin
            rem <= SQ_W'(rem_sh);
            res <= {res[ROOT_W-2:0], 1'b0};
          end
          if (step == 6'(ROOT_W - 1)) busy <= 1'b0;
        end
        OP_DIV: begin
          dividend <= {dividend[ROOT_W+16-2:0], 1'b0};
          if (!dtrial[RADIUS_W+1]) begin
            drem <= dtrial[RADIUS_W:0];
            quo  <= {quo[QUO_W-2:0], 1'b1};
          end else begin
            drem <= {drem[RADIUS_W-1:0], dividend[ROOT_W+16-1]};
            quo  <= {quo[QUO_W-2:0], 1'b0};
          end
          if (step == 6'(ROOT_W + 16 - 1)) busy <= 1'b0;
        end
        default: begin
          // kernel: m^2, m2^2, then times (1+4q)
          unique case (step[1:0])
            2'd0: begin
              m  <= 17'((kprod + 34'd32768) >> 16);
            end
            2'd1: begin
              m4  <= 17'((kprod + 34'd32768) >> 16);
              fac <= 19'(RATIO_ONE) + {q_in[16:0], 2'b00};
            end
            default: begin
              busy <= 1'b0;
            end
          endcase
        end
      endcase
    end
  end

  logic [35:0] wprod;
  logic [35:0] wsum;
  assign wprod = m4 * fac;
  assign wsum  = (wprod + 36'd32768) >> 16;
  assign w_out = (wsum > 36'(RATIO_ONE)) ? W_W'(RATIO_ONE) : W_W'(wsum);
  assign sq_out   = acc;
  assign root_out = res;
  assign quo_out  = quo;

endmodule

>>> hw/rtl/particle_neighbor_distance_weight.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// particle_neighbor_distance_weight
// Fixed-radius pair finder with Wendland C2 weights.
// ---------------------------------------------------------------------------
// Each particle transfer is compared against all stored particles of the set
// in ascending order; one result transfer per pair within the radius, or one
// marker result if none; a full set instead gives one store-full marker. Each
// pair result is held until the next pair or the end of the walk shows whether
// it is the final one. A stored particle is rejected after its distance check;
// a pair goes on through the old distance, root and divide for the current
// ratio, root and divide for the old ratio, and the kernel, all on one shared
// iterative arithmetic unit. The walk also waits while an earlier pair is sent
// and while the receiver stalls. The block takes no new particle and no radius
// write while working or while a result waits for its transfer.
module particle_neighbor_distance_weight import pndw_pkg::*; #(
  parameter int MAX_PARTICLES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [RADIUS_W-1:0]  cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 new_set,
  input  logic [COORD_W-1:0]   cur_x,
  input  logic [COORD_W-1:0]   cur_y,
  input  logic [COORD_W-1:0]   cur_z,
  input  logic [COORD_W-1:0]   old_x,
  input  logic [COORD_W-1:0]   old_y,
  input  logic [COORD_W-1:0]   old_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 pair_valid,
  output logic [IDX_W-1:0]     earlier_index,
  output logic [IDX_W-1:0]     new_index,
  output logic [QC_W-1:0]      cur_norm_dist,
  output logic [QO_W-1:0]      old_norm_dist,
  output logic [W_W-1:0]       weight,
  output logic                 store_full,
  output logic                 last
);

  localparam int AW = $clog2(MAX_PARTICLES);
  localparam int PW = 3 * COORD_W;

  state_t state, state_next;
  logic [RADIUS_W-1:0] radius;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    n;
  logic [AW-1:0]       j;
  logic [PW-1:0]       cur_pos, old_pos;
  logic [PW-1:0]       rd_cur, rd_old;
  logic                found;        // output registers hold a pair not yet sent
  logic                phase_old;    // 0: current ratio, 1: old ratio
  logic [QC_W-1:0]     qc;
  logic [QO_W-1:0]     qo;
  logic [SQ_W-1:0]     dcur;
  logic [SQ_W-1:0]     dold;
  logic                sub;          // 0 start, 1 run
  logic                pend;

  // arithmetic unit
  arith_op_t           a_op;
  logic                a_start, a_busy;
  logic [PW-1:0]       a_pa, a_pb;
  logic [SQ_W-1:0]     a_sq, a_sq_in;
  logic [ROOT_W-1:0]   a_root;
  logic [ROOT_W+16-1:0] a_quo;
  logic [W_W-1:0]      a_w;
  logic [2*RADIUS_W-1:0] r2;

  assign r2 = radius * radius;

  pndw_ram #(.WIDTH(PW), .DEPTH(MAX_PARTICLES)) u_cur (
    .clk(clk), .we(state == ST_STORE), .waddr(n[AW-1:0]), .wdata(cur_pos),
    .raddr(j), .rdata(rd_cur));
  pndw_ram #(.WIDTH(PW), .DEPTH(MAX_PARTICLES)) u_old (
    .clk(clk), .we(state == ST_STORE), .waddr(n[AW-1:0]), .wdata(old_pos),
    .raddr(j), .rdata(rd_old));

  pndw_arith u_arith (
    .clk(clk), .rst(rst), .op(a_op), .start(a_start),
    .pos_a(a_pa), .pos_b(a_pb), .radius(radius), .sq_in(a_sq_in),
    .root_in(a_root), .q_in(qo), .busy(a_busy), .sq_out(a_sq),
    .root_out(a_root), .quo_out(a_quo), .w_out(a_w));

  assign cfg_ready = (state == ST_IDLE) && !pend;
  assign in_ready  = (state == ST_IDLE) && !pend && !cfg_valid;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) state_next = ST_READ;
      end
      ST_READ: begin
        if (n >= CNT_W'(MAX_PARTICLES)) state_next = ST_FULL;
        else if (CNT_W'(j) >= n) state_next = ST_STORE;
        else state_next = ST_WAIT;
      end
      ST_WAIT:     state_next = ST_DIST;
      ST_DIST:     if (sub && !a_busy) state_next = ST_CHECK;
      ST_CHECK: begin
        if (radius == '0 || {4'b0, a_sq} >= {8'b0, r2}) state_next = ST_NEXT;
        else state_next = ST_DIST_OLD;
      end
      ST_DIST_OLD: if (sub && !a_busy) state_next = ST_ROOT;
      ST_ROOT:     if (sub && !a_busy) state_next = ST_DIV;
      ST_DIV: begin
        if (sub && !a_busy) state_next = phase_old ? ST_KERN : ST_ROOT;
      end
      ST_KERN:     if (sub && !a_busy) state_next = ST_EMIT;
      ST_EMIT:     if (!pend && !found) state_next = ST_NEXT;
      ST_NEXT:     state_next = ST_READ;
      ST_STORE:    if (!pend) state_next = ST_IDLE;
      ST_FULL:     if (!pend) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // unit control
  always_comb begin
    a_start = 1'b0;
    a_op    = OP_DIST;
    a_pa    = cur_pos;
    a_pb    = rd_cur;
    a_sq_in = phase_old ? dold : dcur;
    unique case (state)
      ST_DIST:     begin a_op = OP_DIST; a_start = !sub; end
      ST_DIST_OLD: begin a_op = OP_DIST; a_start = !sub; a_pa = old_pos; a_pb = rd_old; end
      ST_ROOT:     begin a_op = OP_ROOT; a_start = !sub; end
      ST_DIV:      begin a_op = OP_DIV;  a_start = !sub; end
      ST_KERN:     begin a_op = OP_KERN; a_start = !sub; end
      default:     ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      radius <= RADIUS_W'(655);
      count  <= '0;
      pend   <= 1'b0;
      sub    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) radius <= cfg_data;
      if (out_valid && out_ready) pend <= 1'b0;
      sub <= (state_next == state);
      unique case (state)
        ST_IDLE: if (in_valid && in_ready) begin
          cur_pos <= {cur_z, cur_y, cur_x};
          old_pos <= {old_z, old_y, old_x};
          n       <= new_set ? '0 : count;
          if (new_set) count <= '0;
          j       <= '0;
          found   <= 1'b0;
        end
        ST_CHECK: begin
          phase_old <= 1'b0;
          dcur      <= a_sq;
        end
        ST_DIST: ;
        ST_DIST_OLD: if (sub && !a_busy) begin
          dold <= a_sq;
        end
        ST_DIV: if (sub && !a_busy) begin
          if (!phase_old) qc <= QC_W'(a_quo);
          else qo <= (a_quo > {{(ROOT_W+16-QO_W){1'b0}}, OLD_RATIO_MAX}) ?
                     OLD_RATIO_MAX : QO_W'(a_quo);
          phase_old <= 1'b1;
        end
        ST_EMIT: if (!pend) begin
          if (found) begin
            // another pair follows, so the held one is not final
            pend  <= 1'b1;
            found <= 1'b0;
          end else begin
            pair_valid    <= 1'b1;
            earlier_index <= IDX_W'(j);
            new_index     <= n[IDX_W-1:0];
            cur_norm_dist <= qc;
            old_norm_dist <= qo;
            weight        <= (qo >= QO_W'(RATIO_ONE)) ? '0 : a_w;
            store_full    <= 1'b0;
            last          <= 1'b0;
            found         <= 1'b1;
          end
        end
        ST_NEXT: j <= j + AW'(1);
        ST_STORE: if (!pend) begin
          count <= n + CNT_W'(1);
          if (!found) begin
            pair_valid <= 1'b0; earlier_index <= '0; new_index <= n[IDX_W-1:0];
            cur_norm_dist <= '0; old_norm_dist <= '0; weight <= '0;
            store_full <= 1'b0;
          end
          last <= 1'b1;
          pend <= 1'b1;
        end
        ST_FULL: if (!pend) begin
          pair_valid <= 1'b0; earlier_index <= '0; new_index <= '0;
          cur_norm_dist <= '0; old_norm_dist <= '0; weight <= '0;
          store_full <= 1'b1; last <= 1'b1; pend <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = pend;

endmodule

>>> hw/rtl/pndw_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pndw_checker
// Port-level checks for the particle neighbor distance weight block.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module pndw_assertions import pndw_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic pair_valid,
  input logic store_full,
  input logic last,
  input logic [W_W-1:0] weight
);

  `ASSERT_IMPL(a_full, clk, rst, out_valid && store_full, last && !pair_valid, "full not final")
  `ASSERT_IMPL(a_nopair_zero, clk, rst, out_valid && !pair_valid, weight == '0, "weight on no-pair")
  `ASSERT_IMPL(a_busy_out, clk, rst, out_valid, !in_ready, "input ready while result pending")
  `ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped")

endmodule

bind particle_neighbor_distance_weight pndw_assertions u_pndw_assertions (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .pair_valid(pair_valid),
  .store_full(store_full), .last(last), .weight(weight));
